// File: src/stq_pkg.sv
// Shared types and codes for the sorted timer queue.
// No dependencies; imported by stq_alu, sorted_timer_queue and the testbench.
package stq_pkg;

    // Request codes on the input channel
    localparam logic [1:0] REQ_SET   = 2'd0;
    localparam logic [1:0] REQ_DEL   = 2'd1;
    localparam logic [1:0] REQ_POP   = 2'd2;
    localparam logic [1:0] REQ_QUERY = 2'd3;

    localparam int unsigned JIFFY_NS_RESET = 32'd10000000;

    // Operations of the shared arithmetic unit
    typedef enum logic [0:0] {
        ALU_ADD_PROD = 1'b0,   // a + registered product
        ALU_SUB      = 1'b1    // a - b, borrow flags a < b
    } t_alu_op;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ADD,
        S_RM_RD,
        S_RM_CHK,
        S_INS_RD,
        S_INS_KEY,
        S_INS_CMP,
        S_HEAD_ID,
        S_HEAD_KEY,
        S_DONE
    } t_state;

endpackage

// File: src/stq_alu.sv
// Shared arithmetic unit: registered jiffy multiply plus one 64-bit adder
// that forms keys, compares keys and computes remaining time. Uses stq_pkg.
module stq_alu (
    input  logic            i_clk,
    input  logic [31:0]     i_mul_a,
    input  logic [29:0]     i_mul_b,
    input  stq_pkg::t_alu_op i_op,
    input  logic [63:0]     i_a,
    input  logic [63:0]     i_b,
    output logic [63:0]     o_result,
    output logic            o_lt
);
    import stq_pkg::*;

    logic [61:0] r_prod;
    logic [63:0] operand;
    logic        carry_in;
    logic [64:0] full;

    // Register the product before it reaches the adder
    always_ff @(posedge i_clk) begin
        r_prod <= {30'd0, i_mul_a} * {32'd0, i_mul_b};
    end

    // Add the product, or subtract b through inversion and carry in
    always_comb begin
        operand  = (i_op == ALU_ADD_PROD) ? {2'b00, r_prod} : ~i_b;
        carry_in = (i_op == ALU_SUB);
        full     = {1'b0, i_a} + {1'b0, operand} + {64'd0, carry_in};
    end

    assign o_result = full[63:0];
    assign o_lt     = (i_op == ALU_SUB) & ~full[64];

endmodule

// File: src/sorted_timer_queue.sv
// Top level of the sorted timer queue: sequencer, slot and order memories.
// Depends on stq_pkg and stq_alu.
//
// Usage: one request transfers on the input channel (i_in_valid/o_in_ready)
// and yields exactly one result on the output channel
// (o_out_valid/i_out_ready). o_in_ready is high only while the sequencer
// is idle. The jiffy length is written through i_cfg_valid/o_cfg_ready,
// which is always ready; write it only while no request is in flight.
// The time from request transfer to result valid does not depend on n,
// the number of pending timers, for a query, but grows with n for delete,
// pop and set; a set that replaces a pending timer walks the list to remove
// it and again to insert. The walk of the order memory, one read port and
// one write port, takes one key read and compare per entry in the adder.
// The result is held in an output register: a new request is taken while
// it waits, and a finished result waits in the last state until the
// output register frees up, so a stalled receiver stalls the sequencer.
// Reset (synchronous, active low) empties the queue, clears all pending
// flags and sets the jiffy length to 10000000 ns; no clearing pass runs.
module sorted_timer_queue #(
    parameter int MAX_TIMERS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_req_type,
    input  logic [5:0]         i_timer_id,
    input  logic [31:0]        i_new_expiry,
    input  logic [31:0]        i_now_jiffies,
    input  logic [63:0]        i_now_time,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_status,
    output logic               o_head_changed,
    output logic [5:0]         o_popped_id,
    output logic signed [63:0] o_remaining_time,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [29:0]        i_cfg_jiffy_ns
);
    import stq_pkg::*;

    localparam int ID_SLOTS = (MAX_TIMERS < 64) ? MAX_TIMERS : 64;
    localparam int PTR_W    = $clog2(ID_SLOTS);
    localparam int CNT_W    = $clog2(ID_SLOTS + 1);

    // Control and payload registers
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_i, n_i;
    logic               r_found, n_found;
    logic [PTR_W-1:0]   r_hold, n_hold;
    logic [PTR_W-1:0]   r_id, n_id;
    logic [63:0]        r_key, n_key;
    logic               r_status, n_status;
    logic               r_head, n_head;
    logic [5:0]         r_popped, n_popped;
    logic [63:0]        r_remain, n_remain;
    logic [1:0]         r_req;
    logic [31:0]        r_exp;
    logic [31:0]        r_nowj;
    logic [63:0]        r_nowt;
    logic [29:0]        r_jiffy;
    logic [ID_SLOTS-1:0] r_pending;

    logic               r_out_valid, n_out_valid;
    logic               r_out_status, n_out_status;
    logic               r_out_head, n_out_head;
    logic [5:0]         r_out_popped, n_out_popped;
    logic [63:0]        r_out_remain, n_out_remain;

    // Memories and their read data
    logic [PTR_W-1:0] order_mem [ID_SLOTS];
    logic [31:0]      exp_mem   [ID_SLOTS];
    logic [63:0]      key_mem   [ID_SLOTS];
    logic [PTR_W-1:0] r_order_rd;
    logic [31:0]      r_exp_rd;
    logic [63:0]      r_key_rd;

    // Memory and flag controls
    logic [PTR_W-1:0] order_raddr;
    logic             order_we;
    logic [PTR_W-1:0] order_waddr;
    logic [PTR_W-1:0] order_wdata;
    logic             slot_we;
    logic             pend_we;
    logic [PTR_W-1:0] pend_idx;
    logic             pend_val;

    // Shared unit hookup
    t_alu_op     alu_op;
    logic [63:0] alu_a;
    logic [63:0] alu_b;
    logic [63:0] alu_result;
    logic        alu_lt;

    logic             in_fire;
    logic             in_ok;
    logic [PTR_W-1:0] in_idx;
    logic [CNT_W-1:0] i_dec;

    assign in_fire     = i_in_valid & o_in_ready;
    assign in_idx      = i_timer_id[PTR_W-1:0];
    assign in_ok       = ({1'b0, i_timer_id} < 7'(ID_SLOTS));
    assign i_dec       = r_i - CNT_W'(1);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    stq_alu u_alu (
        .i_clk    (i_clk),
        .i_mul_a  (r_exp - r_nowj),
        .i_mul_b  (r_jiffy),
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_result (alu_result),
        .o_lt     (alu_lt)
    );

    // Order list memory: one read, one write per cycle
    always_ff @(posedge i_clk) begin
        if (order_we) begin
            order_mem[order_waddr] <= order_wdata;
        end
        r_order_rd <= order_mem[order_raddr];
    end

    // Per-slot expiry and key memories
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            exp_mem[r_id] <= r_exp;
            key_mem[r_id] <= alu_result;
        end
        r_exp_rd <= exp_mem[in_idx];
        r_key_rd <= key_mem[r_order_rd];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_i         <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_pending   <= '0;
            r_jiffy     <= 30'(JIFFY_NS_RESET);
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_i         <= n_i;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (pend_we) begin
                r_pending[pend_idx] <= pend_val;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_jiffy <= i_cfg_jiffy_ns;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_hold       <= n_hold;
        r_id         <= n_id;
        r_key        <= n_key;
        r_status     <= n_status;
        r_head       <= n_head;
        r_popped     <= n_popped;
        r_remain     <= n_remain;
        r_out_status <= n_out_status;
        r_out_head   <= n_out_head;
        r_out_popped <= n_out_popped;
        r_out_remain <= n_out_remain;
        if (in_fire) begin
            r_req  <= i_req_type;
            r_exp  <= i_new_expiry;
            r_nowj <= i_now_jiffies;
            r_nowt <= i_now_time;
        end
    end

    // Sequencer: next state, datapath steering, memory controls
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_i          = r_i;
        n_found      = r_found;
        n_hold       = r_hold;
        n_id         = r_id;
        n_key        = r_key;
        n_status     = r_status;
        n_head       = r_head;
        n_popped     = r_popped;
        n_remain     = r_remain;
        n_out_valid  = r_out_valid & ~i_out_ready;
        n_out_status = r_out_status;
        n_out_head   = r_out_head;
        n_out_popped = r_out_popped;
        n_out_remain = r_out_remain;
        order_raddr  = r_i[PTR_W-1:0];
        order_we     = 1'b0;
        order_waddr  = r_i[PTR_W-1:0];
        order_wdata  = r_hold;
        slot_we      = 1'b0;
        pend_we      = 1'b0;
        pend_idx     = r_id;
        pend_val     = 1'b0;
        alu_op       = ALU_SUB;
        alu_a        = r_key;
        alu_b        = r_key_rd;

        unique case (r_state)
            S_IDLE: begin
                // Fetch the head entry in case of pop or query
                order_raddr = '0;
                if (in_fire) begin
                    n_status = 1'b0;
                    n_head   = 1'b0;
                    n_popped = '0;
                    n_remain = '0;
                    n_i      = '0;
                    n_found  = 1'b0;
                    n_id     = in_idx;
                    n_hold   = in_idx;
                    unique case (i_req_type) inside
                        REQ_SET: begin
                            n_state = in_ok ? S_CHECK : S_DONE;
                        end
                        REQ_DEL: begin
                            if (in_ok && r_pending[in_idx]) begin
                                pend_we  = 1'b1;
                                pend_idx = in_idx;
                                n_status = 1'b1;
                                n_state  = S_RM_RD;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        REQ_POP, REQ_QUERY: begin
                            n_state = (r_cnt != '0) ? S_HEAD_ID : S_DONE;
                        end
                    endcase
                end
            end

            S_CHECK: begin
                // Same jiffy expiry on a pending timer leaves everything alone
                n_status = r_pending[r_id];
                if (r_pending[r_id] && (r_exp_rd == r_exp)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_ADD;
                end
            end

            S_ADD: begin
                // Form the absolute key and store the slot
                alu_op   = ALU_ADD_PROD;
                alu_a    = r_nowt;
                n_key    = alu_result;
                slot_we  = 1'b1;
                pend_we  = 1'b1;
                pend_val = 1'b1;
                n_i      = '0;
                n_found  = 1'b0;
                n_state  = r_status ? S_RM_RD : S_INS_RD;
            end

            S_RM_RD: begin
                if (r_i == r_cnt) begin
                    if (r_found) begin
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                    n_i     = '0;
                    n_found = 1'b0;
                    n_state = (r_req == REQ_SET) ? S_INS_RD : S_DONE;
                end else begin
                    n_state = S_RM_CHK;
                end
            end

            S_RM_CHK: begin
                // Close the gap: move each entry after the removed one down
                if (r_found) begin
                    order_we    = 1'b1;
                    order_waddr = i_dec[PTR_W-1:0];
                    order_wdata = r_order_rd;
                end else if (r_order_rd == r_id) begin
                    n_found = 1'b1;
                    if ((r_i == '0) && (r_req != REQ_POP)) begin
                        n_head = 1'b1;
                    end
                end
                n_i     = r_i + CNT_W'(1);
                n_state = S_RM_RD;
            end

            S_INS_RD: begin
                if (r_i == r_cnt) begin
                    // Append the last held id at the tail
                    order_we = 1'b1;
                    n_cnt    = r_cnt + CNT_W'(1);
                    if (!r_found && (r_i == '0)) begin
                        n_head = 1'b1;
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_INS_KEY;
                end
            end

            S_INS_KEY: begin
                if (r_found) begin
                    // Ripple: drop the held id here, carry the displaced one
                    order_we = 1'b1;
                    n_hold   = r_order_rd;
                    n_i      = r_i + CNT_W'(1);
                    n_state  = S_INS_RD;
                end else begin
                    n_state = S_INS_CMP;
                end
            end

            S_INS_CMP: begin
                // Insert before the first strictly later key
                if (alu_lt) begin
                    order_we = 1'b1;
                    n_hold   = r_order_rd;
                    n_found  = 1'b1;
                    if (r_i == '0) begin
                        n_head = 1'b1;
                    end
                end
                n_i     = r_i + CNT_W'(1);
                n_state = S_INS_RD;
            end

            S_HEAD_ID: begin
                if (r_req == REQ_POP) begin
                    n_popped = 6'(r_order_rd);
                    n_id     = r_order_rd;
                    pend_we  = 1'b1;
                    pend_idx = r_order_rd;
                    n_status = 1'b1;
                    n_i      = '0;
                    n_found  = 1'b0;
                    n_state  = S_RM_RD;
                end else begin
                    n_state = S_HEAD_KEY;
                end
            end

            S_HEAD_KEY: begin
                alu_a    = r_key_rd;
                alu_b    = r_nowt;
                n_remain = alu_result;
                n_status = 1'b1;
                n_state  = S_DONE;
            end

            S_DONE: begin
                // Hand over once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_head   = r_head;
                    n_out_popped = r_popped;
                    n_out_remain = r_remain;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_head_changed   = r_out_head;
    assign o_popped_id      = r_out_popped;
    assign o_remaining_time = r_out_remain;

endmodule

// File: bench/tb_sorted_timer_queue.sv
// Self-checking testbench for sorted_timer_queue: directed table, then random phases.
// Depends on stq_pkg and the sorted_timer_queue RTL; results are checked against
// an in-bench timer list model updated on every request transfer.
module tb_sorted_timer_queue;
    import stq_pkg::*;

    typedef struct packed {
        logic [1:0]  req;
        logic [5:0]  id;
        logic [31:0] expiry;
        logic [31:0] now_j;
        logic [63:0] now_ns;
    } t_req;

    typedef struct packed {
        logic               status;
        logic               head_changed;
        logic [5:0]         popped_id;
        logic signed [63:0] remaining_time;
    } t_reply;

    typedef enum bit { ROW_REQ, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [29:0] jiffy;
        t_req        item;
        bit          typed;
        t_reply      reply;
    } t_row;

    localparam t_reply      NO_REPLY = '0;
    localparam logic [63:0] NS_MAX   = '1;
    localparam logic [31:0] JIF_MAX  = '1;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_in_valid       = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_req_type       = REQ_SET;
    logic [5:0]         i_timer_id       = '0;
    logic [31:0]        i_new_expiry     = '0;
    logic [31:0]        i_now_jiffies    = '0;
    logic [63:0]        i_now_time       = '0;
    logic               o_out_valid;
    logic               i_out_ready      = 1'b0;
    logic               o_status;
    logic               o_head_changed;
    logic [5:0]         o_popped_id;
    logic signed [63:0] o_remaining_time;
    logic               i_cfg_valid      = 1'b0;
    logic               o_cfg_ready;
    logic [29:0]        i_cfg_jiffy_ns   = '0;

    sorted_timer_queue #(.MAX_TIMERS(64)) DUT (.*);

    // Timer list model
    logic        tm_pending [64];
    logic [31:0] tm_expiry  [64];
    logic [63:0] tm_key     [64];
    logic [5:0]  tm_order   [64];
    int          tm_count;
    logic [29:0] tm_jiffy;

    t_reply due_replies [$];
    int     mismatches = 0;
    bit     row_typed  = 1'b0;
    t_reply row_reply  = '0;
    bit     quiet      = 1'b0;
    logic [31:0] jif_now = '0;
    logic [63:0] ns_now  = '0;

    // Directed requests: typed replies only where they are obvious
    t_row plan [26] = '{
        '{ROW_REQ, 30'd0, '{REQ_QUERY, 6'd0, 32'd0, 32'd0, 64'd0}, 1'b1, '{1'b0, 1'b0, 6'd0, 64'sd0}},
        '{ROW_REQ, 30'd0, '{REQ_POP, 6'd63, JIF_MAX, JIF_MAX, NS_MAX}, 1'b1, '{1'b0, 1'b0, 6'd0, 64'sd0}},
        '{ROW_REQ, 30'd0, '{REQ_DEL, 6'd63, 32'd0, 32'd0, 64'd0}, 1'b1, '{1'b0, 1'b0, 6'd0, 64'sd0}},
        '{ROW_REQ, 30'd0, '{REQ_SET, 6'd0, 32'd100, 32'd0, 64'd0}, 1'b1, '{1'b0, 1'b1, 6'd0, 64'sd0}},
        '{ROW_REQ, 30'd0, '{REQ_SET, 6'd0, 32'd100, 32'd50, 64'd7}, 1'b1,
          '{1'b1, 1'b0, 6'd0, 64'sd0}},
        '{ROW_REQ, 30'd0, '{REQ_QUERY, 6'd0, 32'd0, 32'd0, 64'd0}, 1'b1,
          '{1'b1, 1'b0, 6'd0, 64'sd1000000000}},
        '{ROW_REQ, 30'd0, '{REQ_SET, 6'd63, JIF_MAX, 32'd0, NS_MAX}, 1'b0, NO_REPLY},
        '{ROW_REQ, 30'd0, '{REQ_SET, 6'd42, 32'd0, 32'd1, 64'd0}, 1'b0, NO_REPLY},
        '{ROW_REQ, 30'd0, '{REQ_SET, 6'd21, 32'd100, 32'd0, 64'd0}, 1'b0, NO_REPLY},
        '{ROW_REQ, 30'd0, '{REQ_QUERY, 6'd0, 32'd0, 32'd0, NS_MAX}, 1'b0, NO_REPLY},
        '{ROW_REQ, 30'd0, '{REQ_SET, 6'd0, 32'd5, 32'd0, 64'd0}, 1'b0, NO_REPLY},
        '{ROW_REQ, 30'd0, '{REQ_DEL, 6'd21, 32'd0, 32'd0, 64'd0}, 1'b0, NO_REPLY},
        '{ROW_REQ, 30'd0, '{REQ_DEL, 6'd21, 32'd0, 32'd0, 64'd0}, 1'b0, NO_REPLY},
        '{ROW_REQ, 30'd0, '{REQ_POP, 6'd0, 32'd0, 32'd0, 64'd0}, 1'b0, NO_REPLY},
        '{ROW_CFG, 30'd0, '0, 1'b0, NO_REPLY},
        '{ROW_REQ, 30'd0, '{REQ_SET, 6'd7, 32'd123, 32'd9, 64'd500}, 1'b0, NO_REPLY},
        '{ROW_REQ, 30'd0, '{REQ_SET, 6'd8, 32'd1, 32'd2, 64'd500}, 1'b0, NO_REPLY},
        '{ROW_REQ, 30'd0, '{REQ_QUERY, 6'd0, 32'd0, 32'd0, 64'd1000}, 1'b0, NO_REPLY},
        '{ROW_CFG, 30'd1000000000, '0, 1'b0, NO_REPLY},
        '{ROW_REQ, 30'd0, '{REQ_SET, 6'd9, JIF_MAX, 32'd0, 64'd0}, 1'b0, NO_REPLY},
        '{ROW_CFG, 30'd1, '0, 1'b0, NO_REPLY},
        '{ROW_REQ, 30'd0, '{REQ_SET, 6'd10, 32'd2, 32'd0, 64'd0}, 1'b0, NO_REPLY},
        '{ROW_REQ, 30'd0, '{REQ_POP, 6'd0, 32'd0, 32'd0, 64'd0}, 1'b0, NO_REPLY},
        '{ROW_REQ, 30'd0, '{REQ_POP, 6'd0, 32'd0, 32'd0, 64'd0}, 1'b0, NO_REPLY},
        '{ROW_REQ, 30'd0, '{REQ_QUERY, 6'd0, 32'd0, 32'd0, 64'd0}, 1'b0, NO_REPLY},
        '{ROW_CFG, 30'd10000000, '0, 1'b0, NO_REPLY}
    };

    // Clock: period 8
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Position of a timer in the sorted list
    function automatic int find_slot(input logic [5:0] id);
        for (int i = 0; i < tm_count; i++) begin
            if (tm_order[i] == id) return i;
        end
        return tm_count;
    endfunction

    // Close the gap left by a removed list entry
    function automatic void drop_at(input int pos);
        for (int i = pos; i < tm_count - 1; i++) tm_order[i] = tm_order[i + 1];
        tm_count--;
    endfunction

    // Apply one request to the timer list and return its reply
    function automatic t_reply serve_request(input t_req rq);
        t_reply      r;
        int          pos;
        logic [31:0] delta;
        logic [63:0] key;
        logic [5:0]  head;
        r = '0;
        case (rq.req)
            REQ_SET: begin
                r.status = tm_pending[rq.id];
                if (!(tm_pending[rq.id] && tm_expiry[rq.id] == rq.expiry)) begin
                    if (tm_pending[rq.id]) begin
                        pos = find_slot(rq.id);
                        if (pos == 0) r.head_changed = 1'b1;
                        drop_at(pos);
                    end
                    delta = rq.expiry - rq.now_j;
                    key = rq.now_ns + 64'(delta) * 64'(tm_jiffy);
                    // insert after every equal key
                    pos = 0;
                    while (pos < tm_count && !(key < tm_key[tm_order[pos]])) pos++;
                    for (int i = tm_count; i > pos; i--) tm_order[i] = tm_order[i - 1];
                    tm_order[pos] = rq.id;
                    tm_count++;
                    if (pos == 0) r.head_changed = 1'b1;
                    tm_pending[rq.id] = 1'b1;
                    tm_expiry[rq.id] = rq.expiry;
                    tm_key[rq.id] = key;
                end
            end
            REQ_DEL: begin
                if (tm_pending[rq.id]) begin
                    pos = find_slot(rq.id);
                    if (pos == 0) r.head_changed = 1'b1;
                    drop_at(pos);
                    tm_pending[rq.id] = 1'b0;
                    r.status = 1'b1;
                end
            end
            REQ_POP: begin
                if (tm_count > 0) begin
                    head = tm_order[0];
                    drop_at(0);
                    tm_pending[head] = 1'b0;
                    r.popped_id = head;
                    r.status = 1'b1;
                end
            end
            default: begin
                if (tm_count > 0) begin
                    r.remaining_time = tm_key[tm_order[0]] - rq.now_ns;
                    r.status = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    // Track transfers on all three channels and score the results
    always @(posedge i_clk) begin
        t_reply want;
        t_req   rq;
        if (!i_rst_n) begin
            tm_pending = '{default: 1'b0};
            tm_count = 0;
            tm_jiffy = 30'(JIFFY_NS_RESET);
            due_replies.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) tm_jiffy = i_cfg_jiffy_ns;
            if (i_in_valid && o_in_ready) begin
                rq = '{i_req_type, i_timer_id, i_new_expiry, i_now_jiffies, i_now_time};
                want = serve_request(rq);
                if (row_typed) want = row_reply;
                due_replies.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                if (due_replies.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatches++;
                end else begin
                    want = due_replies.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        mismatches++;
                    end
                    if (o_head_changed !== want.head_changed) begin
                        $error("head_changed: expected %0d, got %0d",
                               want.head_changed, o_head_changed);
                        mismatches++;
                    end
                    if (o_popped_id !== want.popped_id) begin
                        $error("popped_id: expected %0d, got %0d", want.popped_id, o_popped_id);
                        mismatches++;
                    end
                    if (o_remaining_time !== want.remaining_time) begin
                        $error("remaining_time: expected %0d, got %0d",
                               want.remaining_time, o_remaining_time);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: stall at random
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Hold the sender until every outstanding reply has arrived
    task automatic settle();
        i_in_valid = 1'b0;
        while (due_replies.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_jiffy(input logic [29:0] value);
        settle();
        i_cfg_jiffy_ns = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Drive one request and hold it until the transfer
    task automatic send_item(input t_req it, input bit typed, input t_reply rep);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        row_typed = typed;
        row_reply = rep;
        i_req_type = it.req;
        i_timer_id = it.id;
        i_new_expiry = it.expiry;
        i_now_jiffies = it.now_j;
        i_now_time = it.now_ns;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Advance the clock of the caller and draw a request; set_pct is the share of sets
    function automatic t_req next_item(input int set_pct);
        t_req it;
        int   r;
        if ($urandom_range(0, 19) == 0) begin
            jif_now = $urandom;
            ns_now = {$urandom, $urandom};
        end else begin
            jif_now += $urandom_range(0, 2);
            if ($urandom_range(0, 3) != 0) ns_now += 64'($urandom_range(1, 40000000));
        end
        it.now_j = jif_now;
        it.now_ns = ns_now;
        it.id = 6'($urandom_range(0, 63));
        it.expiry = $urandom;
        if ($urandom_range(0, 99) < set_pct) begin
            it.req = REQ_SET;
            if ($urandom_range(0, 9) < 7) it.id = 6'($urandom_range(0, 7));
            r = $urandom_range(0, 99);
            if (tm_pending[it.id] && r < 30) it.expiry = tm_expiry[it.id];
            else if (r < 85) it.expiry = jif_now + $urandom_range(0, 300);
        end else begin
            case ($urandom_range(0, 2))
                0: begin
                    it.req = REQ_DEL;
                    if (tm_count > 0 && $urandom_range(0, 9) < 7)
                        it.id = tm_order[$urandom_range(0, tm_count - 1)];
                end
                1: it.req = REQ_POP;
                default: it.req = REQ_QUERY;
            endcase
        end
        return it;
    endfunction

    task automatic run_phase(input logic [29:0] jiffy, input int set_pct, input bit fill,
                             input bit calm, input int n);
        t_req it;
        write_jiffy(jiffy);
        quiet = calm;
        // load every slot, taking the list to full depth
        if (fill) begin
            for (int k = 0; k < 64; k++) begin
                it = next_item(100);
                it.req = REQ_SET;
                it.id = 6'(k);
                send_item(it, 1'b0, NO_REPLY);
            end
        end
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 49) == 0) settle();
            it = next_item(set_pct);
            send_item(it, 1'b0, NO_REPLY);
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) write_jiffy(plan[i].jiffy);
            else send_item(plan[i].item, plan[i].typed, plan[i].reply);
        end

        run_phase(30'd1, 50, 1'b0, 1'b0, 75);
        run_phase(30'd1000000000, 30, 1'b1, 1'b0, 75);
        run_phase(30'($urandom_range(1, 1000000000)), 45, 1'b0, 1'b1, 75);
        run_phase(30'd0, 55, 1'b0, 1'b0, 75);
        run_phase(30'd10000000, 25, 1'b0, 1'b0, 75);
        run_phase(30'($urandom_range(1, 1000000000)), 45, 1'b0, 1'b0, 75);

        // drain, then watch for stray results
        settle();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
